/* hw/rtl/positional_list_engine_top_macros.svh */
// Assertion shorthands used by the top-level file to check this block.
// They expect signals named clk and rst_n in the scope of use.
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/plst_pkg.sv */
package plst_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int CMD_W        = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;

  // Port enables from the sequencer to the element memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

/* hw/rtl/positional_list_engine_top.sv */
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit words,
// addressed by 1-based position, held in a single synchronous memory.
// A command word (in_command, in_position, in_value) is taken at a rising edge
// where start is high and busy is low. Commands are clear, insert before a position,
// delete at a position, get at a position and locate the first equal word.
// Every command yields exactly one result word, shown for one cycle with out_valid
// high; the receiver cannot hold it off, so it must capture it in that cycle.
// Clear, unknown commands, rejected commands and locate on an empty list are
// answered straight from idle; get reads its one entry; insert and delete walk
// the n words that move (fewer than CAPACITY); and locate reads the words in
// order until the first match or the end of the list.
// The memory has one read and one write port, so insert and delete shift one word
// per cycle in a read-modify-write walk. busy falls in the cycle the result
// appears, so the next command can be accepted while the result is on the ports.
// Reset (rst_n low at a clock edge) empties the list and clears busy and out_valid;
// the memory contents are not cleared and need no clearing pass, since only
// entries below the current length are ever read.

module positional_list_engine_top #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [plst_pkg::CMD_W-1:0]         in_command,
  input  logic [plst_pkg::POS_W-1:0]         in_position,
  input  logic signed [plst_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  output logic                               out_status,
  output logic signed [plst_pkg::DATA_W-1:0] out_data_value,
  output logic [plst_pkg::POS_W-1:0]         out_found_position,
  output logic [plst_pkg::POS_W-1:0]         out_current_length,
  output logic                               out_is_empty
);

  // Address width for the element memory and width of the element count.
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  plst_pkg::mem_ctl_t                 mem_ctl;
  logic [AW-1:0]                      mem_raddr;
  logic [AW-1:0]                      mem_waddr;
  logic signed [plst_pkg::DATA_W-1:0] mem_wdata;
  logic signed [plst_pkg::DATA_W-1:0] mem_rdata;

  // The sequencer decodes each command, checks it against the length, and walks
  // the memory. Reads and writes of one walk never touch the same entry in the
  // same cycle, and a new command only starts after the last write has landed.
  plst_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .LW       (LW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_value           (in_value),
    .mem_ctl            (mem_ctl),
    .mem_raddr          (mem_raddr),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_rdata          (mem_rdata),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_data_value     (out_data_value),
    .out_found_position (out_found_position),
    .out_current_length (out_current_length),
    .out_is_empty       (out_is_empty)
  );

  // Element store: one write and one registered read per cycle.
  plst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .raddr (mem_raddr),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

`include "positional_list_engine_top_macros.svh"

  // The memory is only written while a command is being worked on.
  `PLST_ASSERT_NOW(a_no_write_idle, !busy, !mem_ctl.wr_en, "memory write while idle")
  // A walk never reads and writes the same entry in one cycle.
  `PLST_ASSERT_NOW(a_no_rw_clash, mem_ctl.rd_en && mem_ctl.wr_en, mem_raddr != mem_waddr, "read and write hit the same entry")
  // An unknown command is answered at once with an error.
  `PLST_ASSERT_NEXT(a_bad_cmd, start && !busy && in_command > plst_pkg::CMD_LOCATE, out_valid && out_status, "unknown command not rejected")
  // A result only follows an accepted command or the end of a walk.
  `PLST_ASSERT_NOW(a_result_source, out_valid, $past(busy) || $past(start), "result without a command")

endmodule

/* hw/rtl/plst_mem.sv */
module plst_mem #(
  parameter int DEPTH = plst_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  plst_pkg::mem_ctl_t                 ctl,
  input  logic [AW-1:0]                      raddr,
  input  logic [AW-1:0]                      waddr,
  input  logic signed [plst_pkg::DATA_W-1:0] wdata,
  output logic signed [plst_pkg::DATA_W-1:0] rdata
);

  logic signed [plst_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [plst_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/plst_ctrl.sv */
module plst_ctrl #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int LW       = $clog2(CAPACITY + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [plst_pkg::CMD_W-1:0]          in_command,
  input  logic [plst_pkg::POS_W-1:0]          in_position,
  input  logic signed [plst_pkg::DATA_W-1:0]  in_value,
  output plst_pkg::mem_ctl_t                  mem_ctl,
  output logic [AW-1:0]                       mem_raddr,
  output logic [AW-1:0]                       mem_waddr,
  output logic signed [plst_pkg::DATA_W-1:0]  mem_wdata,
  input  logic signed [plst_pkg::DATA_W-1:0]  mem_rdata,
  output logic                                out_valid,
  output logic                                out_status,
  output logic signed [plst_pkg::DATA_W-1:0]  out_data_value,
  output logic [plst_pkg::POS_W-1:0]          out_found_position,
  output logic [plst_pkg::POS_W-1:0]          out_current_length,
  output logic                                out_is_empty
);

  localparam int CW = ((LW > plst_pkg::POS_W) ? LW : plst_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_RD,
    ST_LOC
  } state_t;

  state_t                             state_r, state_nxt;
  logic [LW-1:0]                      len_r, len_nxt;
  logic [LW-1:0]                      cnt_r, cnt_nxt;
  logic [AW-1:0]                      rd_r, rd_nxt;
  logic                               pv_r, pv_nxt;
  logic [AW-1:0]                      pa_r, pa_nxt;
  logic [AW-1:0]                      first_r, first_nxt;
  logic signed [plst_pkg::DATA_W-1:0] val_r, val_nxt;
  logic signed [plst_pkg::DATA_W-1:0] dat_r, dat_nxt;
  logic                               op_del_r, op_del_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_status_r, out_status_nxt;
  logic signed [plst_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic [plst_pkg::POS_W-1:0]         out_found_r, out_found_nxt;
  logic [plst_pkg::POS_W-1:0]         out_len_r, out_len_nxt;
  logic                               out_empty_r, out_empty_nxt;

  logic                               emit;
  logic                               e_status;
  logic signed [plst_pkg::DATA_W-1:0] e_data;
  logic [plst_pkg::POS_W-1:0]         e_found;
  logic [CW-1:0]                      pos_w;
  logic [CW-1:0]                      len_w;
  logic [CW-1:0]                      one_w;

  assign pos_w = CW'(in_position);
  assign len_w = CW'(len_r);
  assign one_w = CW'(1);

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    rd_nxt     = rd_r;
    pv_nxt     = pv_r;
    pa_nxt     = pa_r;
    first_nxt  = first_r;
    val_nxt    = val_r;
    dat_nxt    = dat_r;
    op_del_nxt = op_del_r;
    emit       = 1'b0;
    e_status   = 1'b0;
    e_data     = '0;
    e_found    = '0;
    mem_ctl    = '0;
    mem_raddr  = rd_r;
    mem_waddr  = pa_r;
    mem_wdata  = mem_rdata;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_command)
            plst_pkg::CMD_CLEAR: begin
              len_nxt = '0;
              emit    = 1'b1;
            end
            plst_pkg::CMD_INSERT: begin
              if (len_w >= CW'(CAPACITY) || pos_w == '0 || pos_w > len_w + one_w) begin
                emit     = 1'b1;
                e_status = 1'b1;
              end else begin
                val_nxt   = in_value;
                first_nxt = AW'(pos_w - one_w);
                rd_nxt    = AW'(len_w - one_w);
                cnt_nxt   = LW'(len_w - (pos_w - one_w));
                pv_nxt    = 1'b0;
                state_nxt = ST_INS;
              end
            end
            plst_pkg::CMD_DELETE, plst_pkg::CMD_GET: begin
              if (len_w == '0 || pos_w == '0 || pos_w > len_w) begin
                emit     = 1'b1;
                e_status = 1'b1;
              end else begin
                first_nxt  = AW'(pos_w - one_w);
                rd_nxt     = AW'(pos_w - one_w);
                // A get reads only its own entry; a delete walks to the end.
                cnt_nxt    = (in_command == plst_pkg::CMD_DELETE) ?
                             LW'(len_w - pos_w + one_w) : LW'(1);
                pv_nxt     = 1'b0;
                op_del_nxt = (in_command == plst_pkg::CMD_DELETE);
                state_nxt  = ST_RD;
              end
            end
            plst_pkg::CMD_LOCATE: begin
              if (len_r == '0) begin
                emit = 1'b1;
              end else begin
                val_nxt   = in_value;
                rd_nxt    = '0;
                cnt_nxt   = len_r;
                pv_nxt    = 1'b0;
                state_nxt = ST_LOC;
              end
            end
            default: begin
              emit     = 1'b1;
              e_status = 1'b1;
            end
          endcase
        end
      end

      ST_INS: begin
        // Walk downward: the word read last cycle moves one place up.
        if (pv_r) begin
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = pa_r + AW'(1);
        end
        if (cnt_r != '0) begin
          mem_ctl.rd_en = 1'b1;
          pv_nxt        = 1'b1;
          pa_nxt        = rd_r;
          rd_nxt        = rd_r - AW'(1);
          cnt_nxt       = cnt_r - LW'(1);
        end else begin
          pv_nxt    = 1'b0;
          state_nxt = ST_PUT;
        end
      end

      ST_PUT: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = first_r;
        mem_wdata     = val_r;
        len_nxt       = len_r + LW'(1);
        emit          = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_RD: begin
        // Walk upward: the first word is the one returned, the rest
        // move one place down when deleting.
        if (pv_r) begin
          if (pa_r == first_r) begin
            dat_nxt = mem_rdata;
          end else if (op_del_r) begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = pa_r - AW'(1);
          end
        end
        if (cnt_r != '0) begin
          mem_ctl.rd_en = 1'b1;
          pv_nxt        = 1'b1;
          pa_nxt        = rd_r;
          rd_nxt        = rd_r + AW'(1);
          cnt_nxt       = cnt_r - LW'(1);
        end else begin
          pv_nxt    = 1'b0;
          emit      = 1'b1;
          e_data    = (pv_r && pa_r == first_r) ? mem_rdata : dat_r;
          if (op_del_r) begin
            len_nxt = len_r - LW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_LOC: begin
        if (pv_r && mem_rdata == val_r) begin
          pv_nxt    = 1'b0;
          emit      = 1'b1;
          e_found   = plst_pkg::POS_W'(CW'(pa_r) + one_w);
          state_nxt = ST_IDLE;
        end else if (cnt_r != '0) begin
          mem_ctl.rd_en = 1'b1;
          pv_nxt        = 1'b1;
          pa_nxt        = rd_r;
          rd_nxt        = rd_r + AW'(1);
          cnt_nxt       = cnt_r - LW'(1);
        end else begin
          pv_nxt    = 1'b0;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt  = emit;
    out_status_nxt = emit ? e_status : out_status_r;
    out_data_nxt   = emit ? e_data : out_data_r;
    out_found_nxt  = emit ? e_found : out_found_r;
    out_len_nxt    = emit ? plst_pkg::POS_W'(CW'(len_nxt)) : out_len_r;
    out_empty_nxt  = emit ? (len_nxt == '0) : out_empty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r        <= cnt_nxt;
    rd_r         <= rd_nxt;
    pa_r         <= pa_nxt;
    first_r      <= first_nxt;
    val_r        <= val_nxt;
    dat_r        <= dat_nxt;
    op_del_r     <= op_del_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data_value     = out_data_r;
  assign out_found_position = out_found_r;
  assign out_current_length = out_len_r;
  assign out_is_empty       = out_empty_r;

endmodule
